@@ rtl/tilt_filter_drive_mixer_assert.svh @@
// Assertion macros for the tilt filter drive mixer.
// Used by the top level only; needs nothing else.
`ifndef TILT_FILTER_DRIVE_MIXER_ASSERT_SVH
`define TILT_FILTER_DRIVE_MIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TFDM_ASSERT_SAME(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TFDM_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tfdm_pkg.sv @@
// Shared types and constants for the tilt filter drive mixer.
// No dependencies.
`default_nettype none
package tfdm_pkg;

  localparam int SAMPLE_W = 8;
  localparam int LEVEL_W  = 16;
  localparam int SPEED_W  = 17;
  localparam int DZ_W     = 7;
  localparam int SHIFT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [DZ_W-1:0]    DZ_RESET    = 7'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SHIFT = 2'd1;

  typedef enum logic [3:0] {
    HD_STALL      = 4'd0,
    HD_LEFT       = 4'd1,
    HD_BACK       = 4'd2,
    HD_RIGHT      = 4'd3,
    HD_FWD        = 4'd4,
    HD_FWD_LEFT   = 4'd5,
    HD_BACK_LEFT  = 4'd6,
    HD_BACK_RIGHT = 4'd7,
    HD_FWD_RIGHT  = 4'd8
  } heading_t;

  // Handshake between the filter stage and the mixer stage
  typedef struct packed {
    logic load;   // mixer takes the current levels this cycle
  } mix_ctl_t;

endpackage
`default_nettype wire

@@ rtl/tfdm_lane.sv @@
// One axis of the low-pass filter: Q8.8 state, floor-shift update.
// Depends on tfdm_pkg.
`default_nettype none
module tfdm_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic signed [tfdm_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [tfdm_pkg::SHIFT_W-1:0]  shift,
  output logic signed [tfdm_pkg::LEVEL_W-1:0] level
);
  import tfdm_pkg::*;

  logic signed [LEVEL_W-1:0] avg_r, avg_nxt;
  logic signed [LEVEL_W+1:0] diff, step, sum;

  always_comb begin
    // s*256 - f, 18 bits signed; arithmetic shift floors
    diff    = {{2{sample[SAMPLE_W-1]}}, sample, 8'b0} - {{2{avg_r[LEVEL_W-1]}}, avg_r};
    step    = diff >>> shift;
    sum     = {{2{avg_r[LEVEL_W-1]}}, avg_r} + step;
    avg_nxt = sum[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (load) begin
      avg_r <= avg_nxt;
    end
  end

  assign level = avg_r;

endmodule
`default_nettype wire

@@ rtl/tfdm_mix.sv @@
// Merging stage: heading decision and left/right speed mix, registered.
// Depends on tfdm_pkg.
`default_nettype none
module tfdm_mix (
  input  wire logic                           clk,
  input  wire tfdm_pkg::mix_ctl_t             ctl,
  input  wire logic [tfdm_pkg::DZ_W-1:0]      dead_zone,
  input  wire logic signed [tfdm_pkg::LEVEL_W-1:0] lvl_x,
  input  wire logic signed [tfdm_pkg::LEVEL_W-1:0] lvl_y,
  input  wire logic signed [tfdm_pkg::LEVEL_W-1:0] lvl_z,
  output tfdm_pkg::heading_t                  heading,
  output logic signed [tfdm_pkg::SPEED_W-1:0] speed_left,
  output logic signed [tfdm_pkg::SPEED_W-1:0] speed_right,
  output logic signed [tfdm_pkg::LEVEL_W-1:0] level_x,
  output logic signed [tfdm_pkg::LEVEL_W-1:0] level_y,
  output logic signed [tfdm_pkg::LEVEL_W-1:0] level_z
);
  import tfdm_pkg::*;

  localparam int AW = LEVEL_W + 3;

  logic signed [AW-1:0] x, y, thr, nthr, sl, sr;
  logic xp, xn, yp, yn;
  heading_t hd;

  heading_t hd_r;
  logic signed [SPEED_W-1:0] sl_r, sr_r;
  logic signed [LEVEL_W-1:0] lx_r, ly_r, lz_r;

  always_comb begin
    x    = {{3{lvl_x[LEVEL_W-1]}}, lvl_x};
    y    = {{3{lvl_y[LEVEL_W-1]}}, lvl_y};
    thr  = {{(AW-DZ_W-8){1'b0}}, dead_zone, 8'b0};
    nthr = -thr;
    xp   = x > thr;
    xn   = x < nthr;
    yp   = y > thr;
    yn   = y < nthr;
    priority if (xp && yp) begin
      hd = HD_FWD_LEFT;   sl = x - (y - thr);  sr = x + (y - thr);
    end else if (xn && yp) begin
      hd = HD_BACK_LEFT;  sl = -x - (y - thr); sr = -x + (y - thr);
    end else if (xn && yn) begin
      hd = HD_BACK_RIGHT; sl = -x - (y + thr); sr = -x + (y + thr);
    end else if (xp && yn) begin
      hd = HD_FWD_RIGHT;  sl = x - (y + thr);  sr = x + (y + thr);
    end else if (xp) begin
      hd = HD_FWD;   sl = x;  sr = x;
    end else if (xn) begin
      hd = HD_BACK;  sl = -x; sr = -x;
    end else if (yp) begin
      hd = HD_LEFT;  sl = y;  sr = y;
    end else if (yn) begin
      hd = HD_RIGHT; sl = -y; sr = -y;
    end else begin
      hd = HD_STALL; sl = '0; sr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hd_r <= hd;
      sl_r <= sl[SPEED_W-1:0];
      sr_r <= sr[SPEED_W-1:0];
      lx_r <= lvl_x;
      ly_r <= lvl_y;
      lz_r <= lvl_z;
    end
  end

  assign heading     = hd_r;
  assign speed_left  = sl_r;
  assign speed_right = sr_r;
  assign level_x     = lx_r;
  assign level_y     = ly_r;
  assign level_z     = lz_r;

endmodule
`default_nettype wire

@@ rtl/tilt_filter_drive_mixer.sv @@
// Tilt filter drive mixer. An accepted item is held in the filter lanes, then
// moves into the mixer output registers, where out_valid goes high. Throughput
// 1 item per cycle while out_stall is low; three filter lanes update their Q8.8
// state on accept; heading and speeds are registered as the item leaves them.
// in_stall is high only while both stages hold an item and out_stall is high.
// Synchronous active-low reset clears filter state, valid flags and sets
// dead_zone = 15, filter_shift = 4. Output payload registers are not reset.
// Depends on tfdm_pkg, tfdm_lane, tfdm_mix and the assertion macro header.
`default_nettype none
module tilt_filter_drive_mixer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // config port
  input  wire logic                               cfg_we,
  input  wire logic [tfdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tfdm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [tfdm_pkg::SAMPLE_W-1:0] in_sample_x,
  input  wire logic signed [tfdm_pkg::SAMPLE_W-1:0] in_sample_y,
  input  wire logic signed [tfdm_pkg::SAMPLE_W-1:0] in_sample_z,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [3:0]                              out_heading,
  output logic signed [tfdm_pkg::SPEED_W-1:0]     out_speed_left,
  output logic signed [tfdm_pkg::SPEED_W-1:0]     out_speed_right,
  output logic signed [tfdm_pkg::LEVEL_W-1:0]     out_level_x,
  output logic signed [tfdm_pkg::LEVEL_W-1:0]     out_level_y,
  output logic signed [tfdm_pkg::LEVEL_W-1:0]     out_level_z
);
  import tfdm_pkg::*;

  // Config registers
  logic [DZ_W-1:0]    dead_zone_r;
  logic [SHIFT_W-1:0] shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= DZ_RESET;
      shift_r     <= SHIFT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEAD_ZONE) begin
        dead_zone_r <= cfg_data[DZ_W-1:0];
      end else if (cfg_index == CFG_FILTER_SHIFT) begin
        shift_r <= cfg_data[SHIFT_W-1:0];
      end
    end
  end

  // Pipeline control.
  // Stage A: the lane state registers themselves hold the item's levels.
  // Stage B: the mixer output registers. A new item may enter whenever
  // stage A is empty or is moving on to B in the same cycle.
  logic a_valid_r, a_valid_nxt;
  logic b_valid_r, b_valid_nxt;
  logic in_acc, a_move, out_acc;
  mix_ctl_t mix_ctl;

  always_comb begin
    out_acc     = b_valid_r && !out_stall;
    a_move      = a_valid_r && (!b_valid_r || !out_stall);
    in_stall    = a_valid_r && !a_move;
    in_acc      = in_valid && !in_stall;
    a_valid_nxt = in_acc || (a_valid_r && !a_move);
    b_valid_nxt = a_move || (b_valid_r && !out_acc);
    mix_ctl.load = a_move;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // Three filter lanes, one per axis
  logic signed [LEVEL_W-1:0] lvl_x, lvl_y, lvl_z;

  tfdm_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .load(in_acc),
    .sample(in_sample_x), .shift(shift_r), .level(lvl_x)
  );
  tfdm_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .load(in_acc),
    .sample(in_sample_y), .shift(shift_r), .level(lvl_y)
  );
  tfdm_lane u_lane_z (
    .clk(clk), .rst_n(rst_n), .load(in_acc),
    .sample(in_sample_z), .shift(shift_r), .level(lvl_z)
  );

  // Merging stage: heading and speed mix
  heading_t hd;

  tfdm_mix u_mix (
    .clk(clk), .ctl(mix_ctl), .dead_zone(dead_zone_r),
    .lvl_x(lvl_x), .lvl_y(lvl_y), .lvl_z(lvl_z),
    .heading(hd), .speed_left(out_speed_left), .speed_right(out_speed_right),
    .level_x(out_level_x), .level_y(out_level_y), .level_z(out_level_z)
  );

  assign out_valid   = b_valid_r;
  assign out_heading = hd;

  // Checks
  `include "tilt_filter_drive_mixer_assert.svh"

  `TFDM_ASSERT_SAME(a_stall_needs_item, clk, rst_n, in_stall, a_valid_r && b_valid_r,
    "input stalled with free pipeline space")
  `TFDM_ASSERT_NEXT(a_accept_fills_a, clk, rst_n, in_acc, a_valid_r,
    "accepted item lost from filter stage")
  `TFDM_ASSERT_SAME(a_straight_equal, clk, rst_n,
    out_valid && (hd == HD_STALL || hd == HD_FWD || hd == HD_BACK ||
                  hd == HD_LEFT || hd == HD_RIGHT),
    out_speed_left == out_speed_right,
    "straight heading with unequal drive speeds")

endmodule
`default_nettype wire
